FILE: design/eowm_pkg.sv
// Shared types and constants for the eight-opcode word machine core.
// Holds instruction field positions, opcode codes and the controller/datapath
// command and status bundles. No dependencies.
`default_nettype none

package eowm_pkg;

  // item kinds on the input channel
  localparam logic ITEM_WRITE = 1'b0;
  localparam logic ITEM_STEP  = 1'b1;

  // instruction opcodes, bits 24..22
  localparam logic [2:0] OPC_ADD  = 3'd0;
  localparam logic [2:0] OPC_NOR  = 3'd1;
  localparam logic [2:0] OPC_LW   = 3'd2;
  localparam logic [2:0] OPC_SW   = 3'd3;
  localparam logic [2:0] OPC_BEQ  = 3'd4;
  localparam logic [2:0] OPC_JALR = 3'd5;
  localparam logic [2:0] OPC_HALT = 3'd6;
  localparam logic [2:0] OPC_NOOP = 3'd7;

  // instruction field positions
  localparam int OPC_LSB = 22;
  localparam int RA_LSB  = 19;
  localparam int RB_LSB  = 16;

  // operand select for the address wrap unit
  localparam logic [1:0] RED_ITEM   = 2'd0;  // address of a write item
  localparam logic [1:0] RED_DATA   = 2'd1;  // A + offset for lw / sw
  localparam logic [1:0] RED_BRANCH = 2'd2;  // pc + 1 + offset
  localparam logic [1:0] RED_JALR   = 2'd3;  // jump target: A, or pc + 1 when A and B are the same register

  typedef struct packed {
    logic       capture;       // latch write data, clear per-beat effects
    logic       fetch;         // read instruction word at pc
    logic       decode;        // latch instruction, read register pair
    logic       count;         // bump the saturating step counter
    logic       set_halt;
    logic       pc_next;       // pc <= pc + 1 (wrapped)
    logic       pc_red;        // pc <= wrapped address
    logic       rf_we_alu;     // dest <= add / nor result
    logic       rf_we_link;    // B <= pc + 1 (wrapped)
    logic       rf_we_load;    // B <= memory read data
    logic       red_start;
    logic [1:0] red_sel;
    logic       mem_wr_item;
    logic       mem_wr_store;
    logic       mem_rd_data;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       a_eq_b;
    logic       halted;
    logic       red_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/eowm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module eowm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/eowm_dp.sv
// Datapath of the word machine: pc, step counter, halt flag, register file,
// word memory, address wrap unit and result register. Uses eowm_pkg, eowm_ram.
`default_nettype none

module eowm_dp #(
  parameter int MEM_WORDS = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire eowm_pkg::cmd_t       cmd,
  output eowm_pkg::sts_t            sts,
  input  wire logic [15:0]          in_address,
  input  wire logic signed [31:0]   in_data,
  output logic [15:0]               out_pc_after,
  output logic                      out_halted,
  output logic [31:0]               out_steps_done,
  output logic                      out_reg_written,
  output logic [2:0]                out_reg_index,
  output logic signed [31:0]        out_reg_value,
  output logic                      out_mem_written,
  output logic [15:0]               out_mem_address,
  output logic signed [31:0]        out_mem_value
);
  import eowm_pkg::*;

  localparam int AW       = $clog2(MEM_WORDS);
  localparam bit IS_POW2  = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  localparam int RED_BITS = 33;

  // architectural state
  logic [AW-1:0] pc_r,    pc_nxt;
  logic          halt_r,  halt_nxt;
  logic [31:0]   steps_r, steps_nxt;
  logic [7:0]    rf_vld_r, rf_vld_nxt;
  logic [31:0]   ir_r;
  logic [31:0]   item_data_r;

  // per-beat effects
  logic          eff_rw_r;
  logic [2:0]    eff_ri_r;
  logic [31:0]   eff_rv_r;
  logic          eff_mw_r;
  logic [AW-1:0] eff_ma_r;
  logic [31:0]   eff_mv_r;

  logic [31:0]   mem_q;
  logic [31:0]   rf_a_q, rf_b_q;
  logic [31:0]   va, vb;
  logic [2:0]    ra, rb, rd;
  logic [31:0]   off_sx;
  logic [AW-1:0] pc_inc;
  logic [31:0]   alu;
  logic [31:0]   addr_sum;
  logic [31:0]   jalr_t;
  logic [RED_BITS-1:0] red_opnd;
  logic [AW-1:0] red_q;
  logic          red_done;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_wdata;
  logic          rf_we;
  logic [2:0]    rf_waddr;
  logic [31:0]   rf_wdata;

  assign ra     = ir_r[RA_LSB +: 3];
  assign rb     = ir_r[RB_LSB +: 3];
  assign rd     = ir_r[2:0];
  assign off_sx = {{16{ir_r[15]}}, ir_r[15:0]};
  assign va     = rf_vld_r[ra] ? rf_a_q : 32'd0;
  assign vb     = rf_vld_r[rb] ? rf_b_q : 32'd0;
  assign pc_inc = (pc_r == AW'(MEM_WORDS - 1)) ? '0 : pc_r + AW'(1);

  assign alu      = (ir_r[OPC_LSB +: 3] == OPC_ADD) ? va + vb : ~(va | vb);
  assign addr_sum = va + off_sx;
  assign jalr_t   = (ra == rb) ? 32'(pc_inc) : va;

  always_comb begin
    case (cmd.red_sel)
      RED_ITEM:   red_opnd = RED_BITS'(in_address);
      RED_DATA:   red_opnd = {addr_sum[31], addr_sum};
      RED_BRANCH: red_opnd = RED_BITS'(pc_r) + RED_BITS'(1) + {off_sx[31], off_sx};
      RED_JALR:   red_opnd = {jalr_t[31], jalr_t};
      default:    red_opnd = '0;
    endcase
  end

  // address wrap: signed value modulo MEM_WORDS
  if (IS_POW2) begin : g_wrap_mask
    logic [AW-1:0] red_q_r;
    always_ff @(posedge clk) begin
      if (cmd.red_start) begin
        red_q_r <= red_opnd[AW-1:0];
      end
    end
    assign red_q    = red_q_r;
    assign red_done = 1'b1;
  end else begin : g_wrap_recip
    // Reduce the 33-bit pattern by reciprocal multiplication, then fold the
    // sign back in: a negative value is the pattern minus 2**33.
    // Three register stages: quotient estimate, remainder, final fix.
    localparam logic [25:0]   RECIP = 26'((64'd1 << 33) / 64'(MEM_WORDS));
    localparam logic [16:0]   MOD   = 17'(MEM_WORDS);
    localparam logic [AW-1:0] K33   = AW'((64'd1 << 33) % 64'(MEM_WORDS));
    logic [RED_BITS-1:0] opnd_r;
    logic [25:0]         quo_r;
    logic [17:0]         rem_r;
    logic [AW-1:0]       res_r;
    logic [1:0]          cnt_r;
    logic [17:0]         diff;
    logic [AW-1:0]       rem_fix;
    logic [AW-1:0]       sfix;

    // the estimate is low by at most one, so the remainder is below 2*M
    assign diff    = 18'(34'(opnd_r) - 34'(quo_r) * 34'(MOD));
    assign rem_fix = (rem_r >= 18'(MOD)) ? AW'(rem_r - 18'(MOD)) : AW'(rem_r);
    assign sfix    = (rem_fix >= K33) ? AW'(rem_fix - K33)
                   : AW'((AW+1)'(rem_fix) + (AW+1)'(MOD) - (AW+1)'(K33));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r <= '0;
      end else if (cmd.red_start) begin
        cnt_r <= 2'd3;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.red_start) begin
        opnd_r <= red_opnd;
      end
      quo_r <= 26'((59'(opnd_r) * 59'(RECIP)) >> 33);
      rem_r <= diff;
      res_r <= opnd_r[RED_BITS-1] ? sfix : rem_fix;
    end

    assign red_q    = res_r;
    assign red_done = (cnt_r == '0);
  end

  // word memory
  assign mem_we    = cmd.mem_wr_item | cmd.mem_wr_store;
  assign mem_re    = cmd.fetch | cmd.mem_rd_data;
  assign mem_raddr = cmd.fetch ? pc_r : red_q;
  assign mem_wdata = cmd.mem_wr_item ? item_data_r : vb;

  eowm_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (red_q),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // register file: two copies written together, one per read port
  assign rf_we    = cmd.rf_we_alu | cmd.rf_we_link | cmd.rf_we_load;
  assign rf_waddr = cmd.rf_we_alu ? rd : rb;
  always_comb begin
    if (cmd.rf_we_alu) begin
      rf_wdata = alu;
    end else if (cmd.rf_we_link) begin
      rf_wdata = 32'(pc_inc);
    end else begin
      rf_wdata = mem_q;
    end
  end

  eowm_ram #(.WIDTH(32), .DEPTH(8)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (cmd.decode),
    .raddr (mem_q[RA_LSB +: 3]),
    .rdata (rf_a_q)
  );

  eowm_ram #(.WIDTH(32), .DEPTH(8)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (cmd.decode),
    .raddr (mem_q[RB_LSB +: 3]),
    .rdata (rf_b_q)
  );

  always_comb begin
    pc_nxt     = pc_r;
    halt_nxt   = halt_r;
    steps_nxt  = steps_r;
    rf_vld_nxt = rf_vld_r;
    if (cmd.pc_next) begin
      pc_nxt = pc_inc;
    end
    if (cmd.pc_red) begin
      pc_nxt = red_q;
    end
    if (cmd.set_halt) begin
      halt_nxt = 1'b1;
    end
    if (cmd.count && steps_r != '1) begin
      steps_nxt = steps_r + 32'd1;
    end
    if (rf_we) begin
      rf_vld_nxt[rf_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      halt_r   <= 1'b0;
      steps_r  <= '0;
      rf_vld_r <= '0;
      eff_rw_r <= 1'b0;
      eff_mw_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      halt_r   <= halt_nxt;
      steps_r  <= steps_nxt;
      rf_vld_r <= rf_vld_nxt;
      if (cmd.capture) begin
        eff_rw_r <= 1'b0;
        eff_mw_r <= 1'b0;
      end else begin
        if (rf_we) begin
          eff_rw_r <= 1'b1;
        end
        if (cmd.mem_wr_store) begin
          eff_mw_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_data_r <= in_data;
      eff_ri_r    <= '0;
      eff_rv_r    <= '0;
      eff_ma_r    <= '0;
      eff_mv_r    <= '0;
    end else begin
      if (rf_we) begin
        eff_ri_r <= rf_waddr;
        eff_rv_r <= rf_wdata;
      end
      if (cmd.mem_wr_store) begin
        eff_ma_r <= red_q;
        eff_mv_r <= vb;
      end
    end
    if (cmd.decode) begin
      ir_r <= mem_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pc_after    <= 16'(pc_r);
      out_halted      <= halt_r;
      out_steps_done  <= steps_r;
      out_reg_written <= eff_rw_r;
      out_reg_index   <= eff_ri_r;
      out_reg_value   <= eff_rv_r;
      out_mem_written <= eff_mw_r;
      out_mem_address <= 16'(eff_ma_r);
      out_mem_value   <= eff_mv_r;
    end
  end

  assign sts.opcode   = ir_r[OPC_LSB +: 3];
  assign sts.a_eq_b   = (va == vb);
  assign sts.halted   = halt_r;
  assign sts.red_done = red_done;

  a_halt_from_halt_op: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halt_r) |-> $past(ir_r[OPC_LSB +: 3] == OPC_HALT))
    else $error("halt flag set by an instruction other than halt");

  a_steps_with_halt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_halt |-> cmd.count)
    else $error("halt executed without counting a step");

  a_one_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(rf_we && mem_we))
    else $error("register and memory written in the same cycle");

endmodule

`default_nettype wire

FILE: design/eowm_ctrl.sv
// Controller of the word machine: sequences fetch, decode, execute, address
// wrap and memory access, and owns both handshakes. Uses eowm_pkg.
`default_nettype none

module eowm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_op,
  output logic                out_valid,
  input  wire logic           out_ready,
  output eowm_pkg::cmd_t      cmd,
  input  wire eowm_pkg::sts_t sts
);
  import eowm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_WRAP   = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          step_nxt    = in_op;
          if (in_op == ITEM_WRITE) begin
            cmd.red_start = 1'b1;
            cmd.red_sel   = RED_ITEM;
            state_nxt     = S_WRAP;
          end else if (sts.halted) begin
            state_nxt = S_DONE;
          end else begin
            cmd.fetch = 1'b1;
            state_nxt = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.count = 1'b1;
        case (sts.opcode)
          OPC_ADD, OPC_NOR: begin
            cmd.rf_we_alu = 1'b1;
            cmd.pc_next   = 1'b1;
            state_nxt     = S_DONE;
          end
          OPC_LW, OPC_SW: begin
            cmd.pc_next   = 1'b1;
            cmd.red_start = 1'b1;
            cmd.red_sel   = RED_DATA;
            state_nxt     = S_WRAP;
          end
          OPC_BEQ: begin
            if (sts.a_eq_b) begin
              cmd.red_start = 1'b1;
              cmd.red_sel   = RED_BRANCH;
              state_nxt     = S_WRAP;
            end else begin
              cmd.pc_next = 1'b1;
              state_nxt   = S_DONE;
            end
          end
          OPC_JALR: begin
            cmd.rf_we_link = 1'b1;
            cmd.red_start  = 1'b1;
            cmd.red_sel    = RED_JALR;
            state_nxt      = S_WRAP;
          end
          OPC_HALT: begin
            cmd.set_halt = 1'b1;
            cmd.pc_next  = 1'b1;
            state_nxt    = S_DONE;
          end
          default: begin
            cmd.pc_next = 1'b1;
            state_nxt   = S_DONE;
          end
        endcase
      end
      S_WRAP: begin
        if (sts.red_done) begin
          state_nxt = S_DONE;
          if (step_r == ITEM_WRITE) begin
            cmd.mem_wr_item = 1'b1;
          end else begin
            case (sts.opcode)
              OPC_LW: begin
                cmd.mem_rd_data = 1'b1;
                state_nxt       = S_LOAD;
              end
              OPC_SW: begin
                cmd.mem_wr_store = 1'b1;
              end
              default: begin
                cmd.pc_red = 1'b1;
              end
            endcase
          end
        end
      end
      S_LOAD: begin
        cmd.rf_we_load = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ITEM_WRITE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded but not presented");

  a_no_restart_in_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRAP) |-> !cmd.red_start)
    else $error("wrap unit restarted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_halted_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == ITEM_STEP && sts.halted) |=> (state_r == S_DONE))
    else $error("step after halt did work");

endmodule

`default_nettype wire

FILE: design/eight_opcode_word_machine_core_top.sv
// Top level of the eight-opcode word machine core.
// Depends on eowm_pkg, eowm_ctrl, eowm_dp (and eowm_ram through eowm_dp).
`default_nettype none

// The core is an eight-register, word-addressed machine with one word memory
// of MEM_WORDS 32-bit entries. Each input beat is either a memory write
// (in_op = 0: store in_data at in_address modulo MEM_WORDS) or a step
// (in_op = 1: fetch, decode and execute one instruction at pc). Every input
// beat yields exactly one output beat carrying pc, the halt flag, the
// saturating step count and the register and memory write done by that beat.
// One beat is worked on at a time: in_ready is high only while the core is
// idle, but a finished result sits in the output register so the next beat
// is accepted while it waits. The result is presented in the same cycle as
// in_ready rises again. A write beat passes through the wrap and done states;
// a step is fetched on acceptance and passes through decode, execute and done,
// where a taken beq, jalr, sw or lw also passes the wrap state and a lw then a
// load state; a step after halt goes straight to done. The phases follow from
// the single synchronous memory port (fetch, then data access) and the
// registered register-file read. When MEM_WORDS is not a power of two the
// address wrap is a three-stage reciprocal-multiply remainder unit, which the
// wrap state waits on in every beat that wraps an address (write beats, lw, sw,
// taken beq, jalr). The memory holds no reset state; reading a word that was
// never written gives an unspecified value. Registers and pc reset to zero.
module eight_opcode_word_machine_core_top #(
  parameter int MEM_WORDS = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic [15:0]        in_address,
  input  wire logic signed [31:0] in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_pc_after,
  output logic                    out_halted,
  output logic [31:0]             out_steps_done,
  output logic                    out_reg_written,
  output logic [2:0]              out_reg_index,
  output logic signed [31:0]      out_reg_value,
  output logic                    out_mem_written,
  output logic [15:0]             out_mem_address,
  output logic signed [31:0]      out_mem_value
);
  import eowm_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: handshakes and instruction phases
  eowm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: architectural state, memories and the result register
  eowm_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_address      (in_address),
    .in_data         (in_data),
    .out_pc_after    (out_pc_after),
    .out_halted      (out_halted),
    .out_steps_done  (out_steps_done),
    .out_reg_written (out_reg_written),
    .out_reg_index   (out_reg_index),
    .out_reg_value   (out_reg_value),
    .out_mem_written (out_mem_written),
    .out_mem_address (out_mem_address),
    .out_mem_value   (out_mem_value)
  );

endmodule

`default_nettype wire
